@@ src/twa_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, tables and beat types for the true wind block.
// No dependencies; every other file refers to it by scoped names.
package twa_pkg;

  localparam int CORDIC_STEPS = 18;
  localparam int STEPS_USED   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int STEP_W       = 5;
  localparam int XW           = 40;  // vector component width, Q16 speeds with CORDIC growth
  localparam int ZW           = 36;  // residual angle width, binary angle units

  localparam int FRONT_STAGES = 6;
  localparam int BACK_STAGES  = 4;
  localparam int LATENCY      = FRONT_STAGES + STEPS_USED + 1 + STEPS_USED + BACK_STAGES;

  localparam logic [15:0] FULL_TURN = 16'd36000;
  localparam logic [15:0] HALF_TURN = 16'd18000;

  // angle -> binary angle: a*119304 + floor((a*1456 + 1125) / 2250)
  localparam logic [16:0] PH_BASE  = 17'd119304;
  localparam logic [10:0] PH_MUL   = 11'd1456;
  localparam logic [10:0] PH_OFS   = 11'd1125;
  localparam logic [11:0] PH_DIV   = 12'd2250;
  localparam logic [25:0] PH_RECIP = 26'd61083979;  // floor(2^37 / 2250)
  localparam int          PH_SHIFT = 37;

  localparam logic [16:0] SPD_MAX = 17'h1FFFF;

  function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // squared CORDIC gain in Q32, truncating as each step is folded in
  function automatic logic [63:0] gain_sq();
    logic [63:0] g;
    g = 64'd1 << 32;
    for (int i = 0; i < STEPS_USED; i++) begin
      g = g + (g >> (2 * i));
    end
    return g;
  endfunction

  // gain is about 2.71 in Q32, so it needs 34 bits
  localparam logic [63:0] GAIN_SQ        = gain_sq();
  localparam logic [33:0] GAIN           = GAIN_SQ[33:0];
  localparam logic [32:0] GAIN_HALF      = GAIN_SQ[33:1];
  localparam logic [63:0] SPD_RECIP_FULL = (64'd1 << 62) / GAIN_SQ;
  localparam logic [29:0] SPD_RECIP      = SPD_RECIP_FULL[29:0];

  typedef struct packed {
    logic [15:0] apparent_dir;
    logic [15:0] apparent_speed;
    logic [15:0] heading;
    logic [15:0] vessel_speed;
    logic [15:0] ground_course;
  } twa_in_t;

  typedef struct packed {
    logic [15:0] true_dir;
    logic [16:0] tw_speed;
  } twa_out_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } twa_cell_t;

  typedef struct packed {
    logic [15:0] head;
    logic        neg;
    logic        zero;
  } twa_vside_t;

endpackage

@@ src/twa_cell.sv @@
`timescale 1ns / 1ps
// One CORDIC micro-rotation cell with its output register.
// Depends on twa_pkg for the beat type and arctangent table.
module twa_cell (
  input  logic                        clk,
  input  logic                        vec_mode,
  input  logic [twa_pkg::STEP_W-1:0]  step,
  input  twa_pkg::twa_cell_t          d_in,
  output twa_pkg::twa_cell_t          d_out
);

  twa_pkg::twa_cell_t              cell_r;
  twa_pkg::twa_cell_t              cell_nxt;
  logic signed [twa_pkg::XW-1:0]   dx;
  logic signed [twa_pkg::XW-1:0]   dy;
  logic signed [twa_pkg::ZW-1:0]   ang;
  logic                            up;

  always_comb begin
    dx  = d_in.y >>> step;
    dy  = d_in.x >>> step;
    ang = signed'({{(twa_pkg::ZW-32){1'b0}}, twa_pkg::atan_entry(step)});
    // rotation follows the residual sign, vectoring drives y to zero
    up  = vec_mode ? d_in.y[twa_pkg::XW-1] : ~d_in.z[twa_pkg::ZW-1];
    if (up) begin
      cell_nxt.x = d_in.x - dx;
      cell_nxt.y = d_in.y + dy;
      cell_nxt.z = d_in.z - ang;
    end else begin
      cell_nxt.x = d_in.x + dx;
      cell_nxt.y = d_in.y - dy;
      cell_nxt.z = d_in.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign d_out = cell_r;

endmodule

@@ src/twa_front.sv @@
`timescale 1ns / 1ps
// Input stages: angle reduction, earth-frame TO angles, binary phase and
// quadrant fold ahead of the rotation chain. Depends on twa_pkg.
module twa_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  twa_pkg::twa_in_t    in_data,
  output logic                out_valid,
  output twa_pkg::twa_cell_t  out_app,
  output twa_pkg::twa_cell_t  out_boat,
  output logic [15:0]         out_head
);

  logic [5:0]  v_r;

  // stage 1: reduced inputs
  logic [15:0] adir1_r, head1_r, cog1_r, aspd1_r, bspd1_r;
  logic [15:0] adir_red, head_red, cog_red;

  // stage 2: TO angles, index 0 apparent, 1 boat
  logic [16:0] sum2, sum2a;
  logic [15:0] ang2_r [2];
  logic [15:0] spd2_r [2];
  logic [15:0] head2_r;

  // stage 3..5: phase conversion
  logic [31:0] base3_r [2];
  logic [25:0] n3_r    [2];
  logic [15:0] spd3_r  [2];
  logic [15:0] head3_r;
  logic [31:0] base4_r [2];
  logic [25:0] n4_r    [2];
  logic [14:0] qe4_r   [2];
  logic [15:0] spd4_r  [2];
  logic [15:0] head4_r;
  logic [31:0] ph5_r   [2];
  logic [15:0] spd5_r  [2];
  logic [15:0] head5_r;

  // stage 6: rotation entry
  twa_pkg::twa_cell_t cell6_r [2];
  logic [15:0]        head6_r;

  logic [51:0] qprod [2];
  logic [26:0] rem   [2];
  logic [14:0] qfix  [2];
  twa_pkg::twa_cell_t cell_nxt [2];
  logic [31:0] ph_fold [2];
  logic signed [twa_pkg::XW-1:0] x0 [2];

  always_comb begin
    adir_red = (in_data.apparent_dir >= twa_pkg::FULL_TURN) ?
               in_data.apparent_dir - twa_pkg::FULL_TURN : in_data.apparent_dir;
    head_red = (in_data.heading >= twa_pkg::FULL_TURN) ?
               in_data.heading - twa_pkg::FULL_TURN : in_data.heading;
    cog_red  = (in_data.ground_course >= twa_pkg::FULL_TURN) ?
               in_data.ground_course - twa_pkg::FULL_TURN : in_data.ground_course;
    sum2  = {1'b0, adir1_r} + {1'b0, head1_r} + {1'b0, twa_pkg::HALF_TURN};
    if (sum2 >= {1'b0, twa_pkg::FULL_TURN}) sum2 = sum2 - {1'b0, twa_pkg::FULL_TURN};
    sum2a = (sum2 >= {1'b0, twa_pkg::FULL_TURN}) ? sum2 - {1'b0, twa_pkg::FULL_TURN} : sum2;
    for (int k = 0; k < 2; k++) begin
      qprod[k] = 52'(n3_r[k]) * 52'(twa_pkg::PH_RECIP);
      rem[k]   = 27'(n4_r[k]) - 27'(qe4_r[k]) * 27'(twa_pkg::PH_DIV);
      qfix[k]  = (rem[k] >= 27'(twa_pkg::PH_DIV)) ? qe4_r[k] + 15'd1 : qe4_r[k];
      // second and third quadrant: negate and turn by half a circle
      x0[k]    = signed'({{(twa_pkg::XW-32){1'b0}}, spd5_r[k], 16'd0});
      ph_fold[k] = ph5_r[k];
      if (ph5_r[k][31] ^ ph5_r[k][30]) begin
        x0[k]         = -x0[k];
        ph_fold[k][31] = ~ph5_r[k][31];
      end
      cell_nxt[k].x = x0[k];
      cell_nxt[k].y = '0;
      cell_nxt[k].z = signed'({{(twa_pkg::ZW-32){ph_fold[k][31]}}, ph_fold[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    adir1_r <= adir_red;
    head1_r <= head_red;
    cog1_r  <= cog_red;
    aspd1_r <= in_data.apparent_speed;
    bspd1_r <= in_data.vessel_speed;

    ang2_r[0] <= sum2a[15:0];
    ang2_r[1] <= cog1_r;
    spd2_r[0] <= aspd1_r;
    spd2_r[1] <= bspd1_r;
    head2_r   <= head1_r;

    for (int k = 0; k < 2; k++) begin
      base3_r[k] <= 32'(ang2_r[k]) * 32'(twa_pkg::PH_BASE);
      n3_r[k]    <= 26'(ang2_r[k]) * 26'(twa_pkg::PH_MUL) + 26'(twa_pkg::PH_OFS);
      spd3_r[k]  <= spd2_r[k];
      base4_r[k] <= base3_r[k];
      n4_r[k]    <= n3_r[k];
      qe4_r[k]   <= qprod[k][twa_pkg::PH_SHIFT +: 15];
      spd4_r[k]  <= spd3_r[k];
      ph5_r[k]   <= base4_r[k] + 32'(qfix[k]);
      spd5_r[k]  <= spd4_r[k];
      cell6_r[k] <= cell_nxt[k];
    end
    head3_r <= head2_r;
    head4_r <= head3_r;
    head5_r <= head4_r;
    head6_r <= head5_r;
  end

  assign out_valid = v_r[5];
  assign out_app   = cell6_r[0];
  assign out_boat  = cell6_r[1];
  assign out_head  = head6_r;

endmodule

@@ src/twa_vprep.sv @@
`timescale 1ns / 1ps
// Vector sum of wind and boat velocity, folded into the right half plane
// ahead of the vectoring chain. Depends on twa_pkg.
module twa_vprep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  twa_pkg::twa_cell_t  app,
  input  twa_pkg::twa_cell_t  boat,
  input  logic [15:0]         head,
  output logic                out_valid,
  output twa_pkg::twa_cell_t  out_cell,
  output twa_pkg::twa_vside_t out_side
);

  logic                          valid_r;
  twa_pkg::twa_cell_t            cell_r, cell_nxt;
  twa_pkg::twa_vside_t           side_r, side_nxt;
  logic signed [twa_pkg::XW-1:0] sx, sy;

  always_comb begin
    sx            = app.x + boat.x;
    sy            = app.y + boat.y;
    side_nxt.head = head;
    side_nxt.zero = (sx == '0) && (sy == '0);
    side_nxt.neg  = sx[twa_pkg::XW-1];
    cell_nxt.x    = side_nxt.neg ? -sx : sx;
    cell_nxt.y    = side_nxt.neg ? -sy : sy;
    cell_nxt.z    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    side_r <= side_nxt;
  end

  assign out_valid = valid_r;
  assign out_cell  = cell_r;
  assign out_side  = side_r;

endmodule

@@ src/twa_back.sv @@
`timescale 1ns / 1ps
// Output stages: gain removal by reciprocal with one correction, binary
// angle to hundredths, FROM angle relative to the bow. Depends on twa_pkg.
module twa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  twa_pkg::twa_cell_t  vcell,
  input  twa_pkg::twa_vside_t side,
  output logic                out_valid,
  output twa_pkg::twa_out_t   out_data
);

  logic [3:0]  v_r;

  logic [34:0] magp;
  logic [31:0] phase;

  logic [34:0] mag1_r;
  logic [50:0] prod1_r;
  logic [47:0] aprod1_r;
  logic [15:0] head1_r;

  logic [34:0] mag2_r;
  logic [19:0] qe2_r;
  logic [15:0] ang2_r;
  logic [15:0] head2_r;
  logic [51:0] qsum;
  logic [48:0] asum;
  logic [15:0] ang_raw;

  logic [52:0] qg3_r;
  logic [52:0] n3_r;
  logic [19:0] qe3_r;
  logic [15:0] dir3_r;
  logic [16:0] dsum, dsum_a, dsum_b;

  logic [53:0] diff;
  logic [19:0] q;
  twa_pkg::twa_out_t out_r, out_nxt;

  always_comb begin
    // x is never negative after the fold; the zero vector reads as angle 0
    magp  = (!side.zero && !vcell.x[twa_pkg::XW-1]) ? vcell.x[34:0] : '0;
    phase = side.zero ? 32'd0 : {vcell.z[31] ^ side.neg, vcell.z[30:0]};

    qsum    = 52'(prod1_r) + (52'd1 << 31);
    asum    = 49'(aprod1_r) + (49'd1 << 31);
    ang_raw = asum[47:32];

    dsum   = 17'(ang2_r) + 17'(twa_pkg::HALF_TURN) + 17'(twa_pkg::FULL_TURN) - 17'(head2_r);
    dsum_a = (dsum >= 17'(twa_pkg::FULL_TURN)) ? dsum - 17'(twa_pkg::FULL_TURN) : dsum;
    dsum_b = (dsum_a >= 17'(twa_pkg::FULL_TURN)) ? dsum_a - 17'(twa_pkg::FULL_TURN) : dsum_a;

    // estimate is never high and at most one low
    diff = 54'(n3_r) - 54'(qg3_r);
    q    = (diff >= 54'(twa_pkg::GAIN)) ? qe3_r + 20'd1 : qe3_r;

    out_nxt.true_dir = dir3_r;
    out_nxt.tw_speed = (q > 20'(twa_pkg::SPD_MAX)) ? twa_pkg::SPD_MAX : q[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    mag1_r   <= magp;
    prod1_r  <= 51'(magp[34:14]) * 51'(twa_pkg::SPD_RECIP);
    aprod1_r <= 48'(phase) * 48'(twa_pkg::FULL_TURN);
    head1_r  <= side.head;

    mag2_r  <= mag1_r;
    qe2_r   <= qsum[51:32];
    ang2_r  <= (ang_raw == twa_pkg::FULL_TURN) ? 16'd0 : ang_raw;
    head2_r <= head1_r;

    qg3_r  <= 53'(qe2_r) * 53'(twa_pkg::GAIN);
    n3_r   <= {2'b0, mag2_r, 16'd0} + 53'(twa_pkg::GAIN_HALF);
    qe3_r  <= qe2_r;
    dir3_r <= dsum_b[15:0];

    out_r <= out_nxt;
  end

  assign out_valid = v_r[3];
  assign out_data  = out_r;

endmodule

@@ src/true_wind_from_apparent.sv @@
`timescale 1ns / 1ps
// True wind from apparent wind: rotation, vector sum, vectoring, scaling.
// Throughput one beat per cycle while busy is low; every stage moves on each clock.
// Synchronous active-low reset clears the valid chain; busy is set in reset
// and cleared once reset is released. Results appear for one cycle on out_valid;
// the receiver cannot stall.
module true_wind_from_apparent (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  twa_pkg::twa_in_t  in_data,
  output logic              out_valid,
  output twa_pkg::twa_out_t out_data
);

  localparam int N = twa_pkg::STEPS_USED;

  logic busy_r;
  logic accept;

  // front end: angle prep and quadrant fold
  logic               fr_valid;
  twa_pkg::twa_cell_t fr_app, fr_boat;
  logic [15:0]        fr_head;

  // rotation row: two cells per step, one per vector
  twa_pkg::twa_cell_t rot_app  [0:N];
  twa_pkg::twa_cell_t rot_boat [0:N];
  logic               rot_v_r    [1:N];
  logic [15:0]        rot_head_r [1:N];

  // vectoring row
  logic                vp_valid;
  twa_pkg::twa_vside_t vp_side;
  twa_pkg::twa_cell_t  vec_c [0:N];
  logic                vec_v_r    [1:N];
  twa_pkg::twa_vside_t vec_side_r [1:N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  twa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_data   (in_data),
    .out_valid (fr_valid),
    .out_app   (fr_app),
    .out_boat  (fr_boat),
    .out_head  (fr_head)
  );

  assign rot_app[0]  = fr_app;
  assign rot_boat[0] = fr_boat;

  for (genvar k = 0; k < N; k++) begin : g_rot
    twa_cell u_app (
      .clk      (clk),
      .vec_mode (1'b0),
      .step     (twa_pkg::STEP_W'(k)),
      .d_in     (rot_app[k]),
      .d_out    (rot_app[k+1])
    );
    twa_cell u_boat (
      .clk      (clk),
      .vec_mode (1'b0),
      .step     (twa_pkg::STEP_W'(k)),
      .d_in     (rot_boat[k]),
      .d_out    (rot_boat[k+1])
    );
  end

  // side band keeps step with the rotation row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= N; k++) rot_v_r[k] <= 1'b0;
    end else begin
      rot_v_r[1] <= fr_valid;
      for (int k = 2; k <= N; k++) rot_v_r[k] <= rot_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    rot_head_r[1] <= fr_head;
    for (int k = 2; k <= N; k++) rot_head_r[k] <= rot_head_r[k-1];
  end

  twa_vprep u_vprep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rot_v_r[N]),
    .app       (rot_app[N]),
    .boat      (rot_boat[N]),
    .head      (rot_head_r[N]),
    .out_valid (vp_valid),
    .out_cell  (vec_c[0]),
    .out_side  (vp_side)
  );

  for (genvar k = 0; k < N; k++) begin : g_vec
    twa_cell u_vec (
      .clk      (clk),
      .vec_mode (1'b1),
      .step     (twa_pkg::STEP_W'(k)),
      .d_in     (vec_c[k]),
      .d_out    (vec_c[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= N; k++) vec_v_r[k] <= 1'b0;
    end else begin
      vec_v_r[1] <= vp_valid;
      for (int k = 2; k <= N; k++) vec_v_r[k] <= vec_v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    vec_side_r[1] <= vp_side;
    for (int k = 2; k <= N; k++) vec_side_r[k] <= vec_side_r[k-1];
  end

  twa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vec_v_r[N]),
    .vcell     (vec_c[N]),
    .side      (vec_side_r[N]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ src/twa_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the true wind block, bound to the top level.
// Depends on twa_pkg for beat types and pipeline latency.
module twa_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input twa_pkg::twa_in_t  in_data,
  input logic              out_valid,
  input twa_pkg::twa_out_t out_data
);

  localparam int LAT = twa_pkg::LATENCY;

  a_beat_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted beat gave no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without an accepted beat");

  a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.true_dir < twa_pkg::FULL_TURN))
    else $error("true_dir out of range");

  a_calm: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && !busy && (in_data.apparent_speed == 16'd0)
                        && (in_data.vessel_speed == 16'd0), LAT))
    |-> (out_data.tw_speed == 17'd0))
    else $error("calm input gave nonzero speed");

endmodule

bind true_wind_from_apparent twa_checker u_twa_checker (.*);

@@ tb/sv/tb_true_wind_from_apparent.sv @@
`timescale 1ns / 1ps
// Self-checking bench for true_wind_from_apparent: a bit-exact CORDIC predictor,
// a queued command driver with random gaps, and a strobe monitor. Needs twa_pkg.
module tb_true_wind_from_apparent;

  localparam int WDOG_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  twa_pkg::twa_in_t   in_data = '0;
  logic               out_valid;
  twa_pkg::twa_out_t  out_data;

  true_wind_from_apparent dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #2 clk = ~clk;

  twa_pkg::twa_in_t  pending_beats[$];
  twa_pkg::twa_out_t wind_expected[$];
  bit       feed_done = 1'b0;
  int       err_count = 0;
  int       idle_cycles = 0;

  // arctangent of 2^-i in binary-angle units
  function automatic longint arc_step(int i);
    logic [31:0] t [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
    return longint'(t[i]);
  endfunction

  // polar (speed, TO angle) -> north/east components, Q16
  function automatic void polar_to_ne(input int unsigned spd, input int unsigned ang,
                                      output longint xo, output longint yo);
    logic [31:0] ph;
    longint x, y, z, dx, dy;
    ph = 32'(((longint'(ang) << 32) + 18000) / 36000);
    x = longint'(spd) << 16;
    y = 0;
    if (ph[31:30] == 2'd1 || ph[31:30] == 2'd2) begin
      x = -x;
      ph = ph + 32'h80000000;
    end
    z = longint'($signed(ph));
    for (int i = 0; i < twa_pkg::STEPS_USED; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_step(i);
      end else begin
        x += dx; y -= dy; z += arc_step(i);
      end
    end
    xo = x;
    yo = y;
  endfunction

  function automatic twa_pkg::twa_out_t true_wind_of(twa_pkg::twa_in_t b);
    int unsigned adir, head, cog, app_to, to_ang;
    longint xa, ya, xb, yb, x, y, z, dx, dy;
    logic [31:0] acc;
    logic [63:0] g, spd;
    twa_pkg::twa_out_t r;
    adir = 32'(b.apparent_dir) % 36000;
    head = 32'(b.heading) % 36000;
    cog = 32'(b.ground_course) % 36000;
    app_to = (adir + head + 18000) % 36000;
    polar_to_ne(32'(b.apparent_speed), app_to, xa, ya);
    polar_to_ne(32'(b.vessel_speed), cog, xb, yb);
    x = xa + xb;
    y = ya + yb;
    acc = '0;
    z = 0;
    if (x == 0 && y == 0) begin
      x = 0;
    end else begin
      if (x < 0) begin
        x = -x; y = -y; acc = 32'h80000000;
      end
      for (int i = 0; i < twa_pkg::STEPS_USED; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y < 0) begin
          x -= dx; y += dy; z -= arc_step(i);
        end else begin
          x += dx; y -= dy; z += arc_step(i);
        end
      end
    end
    acc = acc + 32'(z);
    to_ang = int'(((64'(acc) * 36000) + 64'h80000000) >> 32) % 36000;
    r.true_dir = 16'((to_ang + 18000 + 36000 - head) % 36000);
    g = 64'd1 << 32;
    for (int i = 0; i < twa_pkg::STEPS_USED; i++) g += g >> (2 * i);
    if (x <= 0) spd = 0;
    else spd = ((64'(x) << 16) + (g >> 1)) / g;
    if (spd > 131071) spd = 131071;
    r.tw_speed = spd[16:0];
    return r;
  endfunction

  function automatic logic [15:0] rand_angle();
    // mostly in range, sometimes beyond a full turn to exercise reduction
    if ($urandom_range(9) == 0) return 16'($urandom_range(65535));
    return 16'($urandom_range(35999));
  endfunction

  function automatic logic [15:0] rand_speed();
    case ($urandom_range(5))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(15));
      2: return 16'(65535 - $urandom_range(31));
      default: return 16'($urandom_range(4000));
    endcase
  endfunction

  function automatic int gap_len();
    if ($urandom_range(3) != 0) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 10);
    return $urandom_range(3, 1);
  endfunction

  // stimulus: directed corners first, then random sensor updates
  initial begin
    twa_pkg::twa_in_t b;
    pending_beats.push_back('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0});        // zero sum
    pending_beats.push_back('{16'd0, 16'd0, 16'd12345, 16'd0, 16'd0});
    pending_beats.push_back('{16'd35999, 16'd65535, 16'd35999, 16'd65535, 16'd35999});
    pending_beats.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    pending_beats.push_back('{16'd36000, 16'd1000, 16'd36000, 16'd1000, 16'd36000});
    // head wind equal to boat speed, cancelling to zero vector
    pending_beats.push_back('{16'd0, 16'd500, 16'd0, 16'd500, 16'd0});
    pending_beats.push_back('{16'd0, 16'd500, 16'd9000, 16'd500, 16'd9000});
    pending_beats.push_back('{16'd18000, 16'd65535, 16'd0, 16'd65535, 16'd0});
    pending_beats.push_back('{16'd9000, 16'd1, 16'd27000, 16'd1, 16'd18000});
    pending_beats.push_back('{16'd27000, 16'd2000, 16'd4500, 16'd0, 16'd0});
    pending_beats.push_back('{16'd0, 16'd0, 16'd100, 16'd777, 16'd31500});
    pending_beats.push_back('{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
    pending_beats.push_back('{16'hAAAA, 16'h5555, 16'h2AAA, 16'h5555, 16'h2AAA});
    for (int n = 0; n < 1250; n++) begin
      b.apparent_dir = rand_angle();
      b.apparent_speed = rand_speed();
      b.heading = rand_angle();
      b.vessel_speed = rand_speed();
      b.ground_course = rand_angle();
      pending_beats.push_back(b);
    end
    feed_done = 1'b1;
  end

  // reset held low at the start, then released once
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: a beat goes when start is high and busy low at the edge
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        wind_expected.push_back(true_wind_of(in_data));
        void'(pending_beats.pop_front());
        gap_left = gap_len();
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          start <= 1'b1;
          in_data <= pending_beats[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe is checked against the oldest expectation
  always @(posedge clk) begin
    twa_pkg::twa_out_t exp_r;
    if (rst_n && out_valid) begin
      if (wind_expected.size() == 0) begin
        $error("unexpected result true_dir=%0d tw_speed=%0d",
               out_data.true_dir, out_data.tw_speed);
        err_count++;
      end else begin
        exp_r = wind_expected.pop_front();
        if (out_data.true_dir !== exp_r.true_dir) begin
          $error("true_dir expected %0d got %0d", exp_r.true_dir, out_data.true_dir);
          err_count++;
        end
        if (out_data.tw_speed !== exp_r.tw_speed) begin
          $error("tw_speed expected %0d got %0d", exp_r.tw_speed, out_data.tw_speed);
          err_count++;
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    forever begin
      @(posedge clk);
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("tb_true_wind_from_apparent: FAIL");
        $finish;
      end
      if (feed_done && rst_n && pending_beats.size() == 0 && !start
          && wind_expected.size() == 0) begin
        repeat (twa_pkg::LATENCY + 10) @(posedge clk);
        if (err_count == 0) $display("tb_true_wind_from_apparent: PASS");
        else $display("tb_true_wind_from_apparent: FAIL");
        $finish;
      end
    end
  end

endmodule

@@ true_wind_from_apparent.f @@
src/twa_pkg.sv
src/twa_cell.sv
src/twa_front.sv
src/twa_vprep.sv
src/twa_back.sv
src/true_wind_from_apparent.sv
src/twa_checker.sv
tb/sv/tb_true_wind_from_apparent.sv
